// ===== rtl/uvs_pkg.sv =====
// uvs_pkg: shared types and constants for the uv sphere triangle generator
// no dependencies
package uvs_pkg;

    localparam int RES_W      = 9;
    localparam int COORD_W    = 16;
    localparam int DEF_MAX_RES = 256;
    localparam int DEF_FRAC_BITS = 15;
    localparam logic [RES_W-1:0] RES_RESET = 9'd10;

    localparam int Q       = 30;
    localparam int QW      = 31;   // unsigned q30 value, below 2.0
    localparam logic [QW-1:0] Q30_ONE = 31'h4000_0000;
    localparam logic [QW-1:0] HALF_PI_Q30 = 31'd1686629713;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic                      triangle_sel;
        logic [1:0]                corner;
        logic                      last;
        logic                      mesh_done;
    } vertex_t;

    typedef struct packed {
        logic start;
        logic busy;
    } unit_ctl_t;

    // divisor k*(k-1) of the taylor horner step
    function automatic logic [7:0] taylor_div(input logic [3:0] k);
        logic [7:0] r;
        r = 8'(k) * 8'(k - 4'd1);
        return r;
    endfunction

endpackage

// ===== rtl/uvs_if.sv =====
// uvs_if: valid/ready channel interfaces for the input and vertex streams
// depends on uvs_pkg
interface uvs_in_if;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface uvs_out_if;
    logic valid;
    logic ready;
    uvs_pkg::vertex_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/uv_sphere_triangle_generator.sv =====
// uv_sphere_triangle_generator: top level, configuration register and
// sequencer; depends on uvs_pkg, uvs_if, uvs_seq
//
// usage: each beat on the input channel (restart bit) produces one grid cell
// of a unit uv sphere, six vertex beats on the output channel: triangle 0
// then triangle 1, three corners each, coordinates signed q1.15.
// resolution is to be written through cfg_we / cfg_data only while the
// block is idle; the block does not enforce this. zero acts as one,
// values above MAX_RES act as MAX_RES. one item is worked on at a time.
// four angles are each reduced by a bit-serial divider and evaluated by
// a taylor series using a shift-add multiplier and the divider per term;
// each vertex takes two more multiplies. a result waits in the output
// register while the receiver stalls; the sequencer holds before loading
// the next vertex until it is taken.
// reset returns resolution to 10 and the cell counters to cell zero.
module uv_sphere_triangle_generator #(
    parameter int MAX_RES   = uvs_pkg::DEF_MAX_RES,
    parameter int FRAC_BITS = uvs_pkg::DEF_FRAC_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [uvs_pkg::RES_W-1:0] cfg_data,
    uvs_in_if.sink                    in_ch,
    uvs_out_if.source                 out_ch
);
    import uvs_pkg::*;

    logic [RES_W-1:0] res_reg, res_next;

    always_comb
    begin
        res_next = cfg_we ? cfg_data : res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_reg <= RES_RESET;
        else
            res_reg <= res_next;
    end

    uvs_seq #(.MAX_RES(MAX_RES), .FRAC_BITS(FRAC_BITS)) u_seq (
        .clk(clk), .rst_n(rst_n), .resolution(res_reg),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_restart(in_ch.restart),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
    );

`ifndef SYNTHESIS
    a_cfg_take: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> res_reg == $past(cfg_data)) else $error("config write lost");
    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> $stable(res_reg)) else $error("config changed without write");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("stalled vertex beat changed");
`endif
endmodule

// ===== rtl/uvs_serdiv.sv =====
// uvs_serdiv: bit-serial restoring divider, one quotient bit per cycle
// depends on nothing
module uvs_serdiv #(
    parameter int NW = 34,
    parameter int DW = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg, quo_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[DW-1:0], quo_reg[NW-1]};
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift one numerator bit in, subtract if it fits
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg[DW-1:0];

`ifndef SYNTHESIS
    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0) else $error("divider busy with zero count");
    a_rem_lt: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start |-> rem_reg < {1'b0, den_reg})
        else $error("partial remainder not below divisor");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg) else $error("divider did not start");
`endif
endmodule

// ===== rtl/uvs_sermul.sv =====
// uvs_sermul: shift-add multiplier, one multiplier bit per cycle
// depends on nothing
module uvs_sermul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             busy,
    output logic [AW+BW-1:0] prod
);
    localparam int CW = $clog2(BW + 1);

    logic [AW+BW-1:0] acc_reg, acc_next;
    logic [AW-1:0]    a_reg, a_next;
    logic [BW-1:0]    b_reg, b_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [AW:0]      hi_sum;

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        hi_sum    = {1'b0, acc_reg[AW+BW-1:BW]} + (b_reg[0] ? {1'b0, a_reg} : '0);
        if (start)
        begin
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
            cnt_next  = CW'(BW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // add-and-shift right, lsb of multiplier first
            acc_next = {hi_sum, acc_reg[BW-1:1]};
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign busy = busy_reg;
    assign prod = acc_reg;

`ifndef SYNTHESIS
    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0) else $error("multiplier busy with zero count");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg) else $error("multiplier did not start");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start && cnt_reg == CW'(1) |=> !busy_reg)
        else $error("multiplier overran");
`endif
endmodule

// ===== rtl/uvs_seq.sv =====
// uvs_seq: cell sequencer; angle reduction, taylor sine/cosine and vertex
// products via shared serial uvs_serdiv and uvs_sermul; depends on uvs_pkg too
module uvs_seq #(
    parameter int MAX_RES   = uvs_pkg::DEF_MAX_RES,
    parameter int FRAC_BITS = uvs_pkg::DEF_FRAC_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [uvs_pkg::RES_W-1:0]  resolution,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_restart,
    output logic                       out_valid,
    input  logic                       out_ready,
    output uvs_pkg::vertex_t           out_data
);
    import uvs_pkg::*;

    localparam int IW = $clog2(MAX_RES + 1);     // counter width
    localparam int NW = IW + 3;                  // angle numerator width
    localparam int DNW = 62;                     // q30 angle numerator
    localparam int MW = 32;                      // signed magnitude word
    localparam int RSH_XY = 60 - FRAC_BITS;
    localparam int RSH_Z  = 30 - FRAC_BITS;
    localparam logic [63:0] FMAX = (64'd1 << FRAC_BITS) - 64'd1;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_QDIV  = 16'h0002,
        S_XMUL  = 16'h0004,
        S_XDIV  = 16'h0008,
        S_X2    = 16'h0010,
        S_TMUL  = 16'h0020,
        S_TDIV  = 16'h0040,
        S_SMUL  = 16'h0080,
        S_ANG   = 16'h0100,
        S_VMUL  = 16'h0200,
        S_VOUT  = 16'h0400,
        S_VWAIT = 16'h0800,
        S_WAIT1 = 16'h1000,
        S_WAIT2 = 16'h2000,
        S_WAIT3 = 16'h4000,
        S_WAIT4 = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    logic [IW-1:0] ti_reg, ti_next, pj_reg, pj_next;
    logic [IW-1:0] n;
    logic [1:0]    ang_reg, ang_next;     // which of four angles
    logic          cosp_reg, cosp_next;   // 0 sine series, 1 cosine series
    logic [3:0]    k_reg, k_next;
    logic [1:0]    quad_reg, quad_next;
    logic [QW-1:0] x_reg, x_next, t_reg, t_next, us_reg, us_next;
    logic [MW-1:0] x2_reg, x2_next;       // x squared reaches about 2.47 in q30
    logic signed [MW-1:0] sc_reg [4], sc_next [4];  // sin t1, sin t2 ...
    logic signed [MW-1:0] cc_reg [4], cc_next [4];
    logic [2:0]    v_reg, v_next;
    logic          vpass_reg, vpass_next;  // 0 x product, 1 y product
    logic signed [COORD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic          final_reg, final_next;
    vertex_t       vout_reg, vout_next;
    logic          vvalid_reg, vvalid_next;

    logic          d_start, m_start;
    unit_ctl_t     dctl, mctl;
    logic [DNW-1:0] d_num;
    logic [RES_W-1:0] d_den;
    logic [DNW-1:0] d_quo;
    logic [RES_W-1:0] d_rem;
    logic [MW-1:0] m_a, m_b;
    logic [2*MW-1:0] m_prod;
    logic [NW-1:0] ang_num;
    logic          a_sel, b_sel;
    logic signed [MW-1:0] ps, pc, fa, fb;
    logic          neg_p;
    logic [63:0]   mag, rnd;
    logic [QW-1:0] sub_v;

    assign n = (resolution == '0) ? IW'(1) :
               (resolution > RES_W'(MAX_RES) && RES_W > IW) ? IW'(MAX_RES) :
               (32'(resolution) > MAX_RES) ? IW'(MAX_RES) : IW'(resolution);

    assign dctl.start = d_start;
    assign mctl.start = m_start;

    uvs_serdiv #(.NW(DNW), .DW(RES_W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(d_start), .num(d_num), .den(d_den),
        .busy(dctl.busy), .quo(d_quo), .rem(d_rem)
    );

    uvs_sermul #(.AW(MW), .BW(MW)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(m_start), .a(m_a), .b(m_b),
        .busy(mctl.busy), .prod(m_prod)
    );

    // numerator of the current angle in quarter turns
    always_comb
    begin
        unique case (ang_reg)
            2'd0: ang_num = NW'(4) * NW'(ti_reg);
            2'd1: ang_num = NW'(4) * (NW'(ti_reg) + NW'(1));
            2'd2: ang_num = NW'(2) * NW'(pj_reg);
            default: ang_num = NW'(2) * (NW'(pj_reg) + NW'(1));
        endcase
    end

    // vertex angle selection: theta index, phi index per corner
    always_comb
    begin
        unique case (v_reg)
            3'd1, 3'd3, 3'd4: a_sel = 1'b1;
            default:          a_sel = 1'b0;
        endcase
        unique case (v_reg)
            3'd2, 3'd4, 3'd5: b_sel = 1'b1;
            default:          b_sel = 1'b0;
        endcase
        fa = vpass_reg ? sc_reg[{1'b0, a_sel}] : cc_reg[{1'b0, a_sel}];
        fb = sc_reg[{1'b1, b_sel}];
    end

    // sign-magnitude of the product, rounded, saturated
    function automatic logic signed [COORD_W-1:0] sat_field(
        input logic neg, input logic [63:0] m);
        logic [63:0] lim;
        logic signed [COORD_W-1:0] r;
        lim = neg ? FMAX + 64'd1 : FMAX;
        if (lim > 64'd32768 && neg) lim = 64'd32768;
        if (lim > 64'd32767 && !neg) lim = 64'd32767;
        if (m > lim) m = lim;
        r = neg ? -COORD_W'(m) : COORD_W'(m);
        return r;
    endfunction

    always_comb
    begin
        neg_p = fa[MW-1] ^ fb[MW-1];
        mag   = m_prod;
        rnd   = (mag + (64'd1 << (RSH_XY - 1))) >> RSH_XY;
        sub_v = (d_quo[QW-1:0] > Q30_ONE || d_quo[DNW-1:QW] != '0) ? '0 :
                Q30_ONE - d_quo[QW-1:0];
        ps = MW'(us_reg);
        pc = MW'(t_reg);
    end

    always_comb
    begin
        state_next  = state_reg;
        ti_next     = ti_reg;
        pj_next     = pj_reg;
        ang_next    = ang_reg;
        cosp_next   = cosp_reg;
        k_next      = k_reg;
        quad_next   = quad_reg;
        x_next      = x_reg;
        x2_next     = x2_reg;
        t_next      = t_reg;
        us_next     = us_reg;
        sc_next     = sc_reg;
        cc_next     = cc_reg;
        v_next      = v_reg;
        vpass_next  = vpass_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        final_next  = final_reg;
        vout_next   = vout_reg;
        vvalid_next = vvalid_reg;
        d_start     = 1'b0;
        d_num       = '0;
        d_den       = RES_W'(n);
        m_start     = 1'b0;
        m_a         = '0;
        m_b         = '0;
        in_ready    = 1'b0;

        if (vvalid_reg && out_ready)
            vvalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_restart || ti_reg >= n || pj_reg >= n)
                    begin
                        ti_next = '0;
                        pj_next = '0;
                    end
                    ang_next   = 2'd0;
                    state_next = S_WAIT1;
                end
            end
            S_WAIT1:
            begin
                // a / n gives quadrant and remainder
                d_start    = 1'b1;
                d_num      = DNW'(ang_num);
                final_next = (ti_reg == n - IW'(1)) && (pj_reg == n - IW'(1));
                state_next = S_QDIV;
            end
            S_QDIV:
                if (!dctl.busy)
                begin
                    quad_next  = d_quo[1:0];
                    m_start    = 1'b1;
                    m_a        = MW'(d_rem);
                    m_b        = MW'(HALF_PI_Q30);
                    state_next = S_XMUL;
                end
            S_XMUL:
                if (!mctl.busy)
                begin
                    d_start    = 1'b1;
                    d_num      = DNW'(m_prod);
                    state_next = S_XDIV;
                end
            S_XDIV:
                if (!dctl.busy)
                begin
                    x_next     = d_quo[QW-1:0];
                    m_start    = 1'b1;
                    m_a        = MW'(d_quo[QW-1:0]);
                    m_b        = MW'(d_quo[QW-1:0]);
                    state_next = S_X2;
                end
            S_X2:
                if (!mctl.busy)
                begin
                    x2_next    = MW'(m_prod >> Q);
                    t_next     = Q30_ONE;
                    k_next     = 4'd15;
                    cosp_next  = 1'b0;
                    state_next = S_WAIT2;
                end
            S_WAIT2:
            begin
                m_start    = 1'b1;
                m_a        = MW'(x2_reg);
                m_b        = MW'(t_reg);
                state_next = S_TMUL;
            end
            S_TMUL:
                if (!mctl.busy)
                begin
                    d_start    = 1'b1;
                    d_num      = DNW'(m_prod >> Q);
                    d_den      = RES_W'(taylor_div(k_reg));
                    state_next = S_TDIV;
                end
            S_TDIV:
                if (!dctl.busy)
                begin
                    t_next = sub_v;
                    k_next = k_reg - 4'd2;
                    if (k_reg == (cosp_reg ? 4'd2 : 4'd3))
                    begin
                        if (!cosp_reg)
                        begin
                            m_start    = 1'b1;
                            m_a        = MW'(x_reg);
                            m_b        = MW'(sub_v);
                            state_next = S_SMUL;
                        end
                        else
                            state_next = S_ANG;
                    end
                    else
                        state_next = S_WAIT2;
                end
            S_SMUL:
                if (!mctl.busy)
                begin
                    us_next    = QW'(m_prod >> Q);
                    t_next     = Q30_ONE;
                    k_next     = 4'd14;
                    cosp_next  = 1'b1;
                    state_next = S_WAIT2;
                end
            S_ANG:
            begin
                // quadrant symmetry
                unique case (quad_reg)
                    2'd0: begin sc_next[ang_reg] = ps;  cc_next[ang_reg] = pc;  end
                    2'd1: begin sc_next[ang_reg] = pc;  cc_next[ang_reg] = -ps; end
                    2'd2: begin sc_next[ang_reg] = -ps; cc_next[ang_reg] = -pc; end
                    default: begin sc_next[ang_reg] = -pc; cc_next[ang_reg] = ps; end
                endcase
                if (ang_reg == 2'd3)
                begin
                    v_next     = '0;
                    vpass_next = 1'b0;
                    state_next = S_WAIT3;
                end
                else
                begin
                    ang_next   = ang_reg + 2'd1;
                    state_next = S_WAIT1;
                end
            end
            S_WAIT3:
            begin
                m_start    = 1'b1;
                m_a        = MW'(fa[MW-1] ? -fa : fa);
                m_b        = MW'(fb[MW-1] ? -fb : fb);
                state_next = S_VMUL;
            end
            S_VMUL:
                if (!mctl.busy)
                begin
                    if (!vpass_reg)
                    begin
                        cx_next    = sat_field(neg_p && rnd != '0, rnd);
                        vpass_next = 1'b1;
                        state_next = S_WAIT3;
                    end
                    else
                    begin
                        cy_next    = sat_field(neg_p && rnd != '0, rnd);
                        state_next = S_VOUT;
                    end
                end
            S_VOUT:
                if (!vvalid_reg || out_ready)
                begin
                    vout_next.coord_x      = cx_reg;
                    vout_next.coord_y      = cy_reg;
                    vout_next.coord_z      = sat_field(cc_reg[{1'b1, b_sel}][MW-1],
                        64'((cc_reg[{1'b1, b_sel}][MW-1] ? -cc_reg[{1'b1, b_sel}]
                             : cc_reg[{1'b1, b_sel}]) + (MW'(1) << (RSH_Z - 1))) >> RSH_Z);
                    vout_next.triangle_sel = (v_reg >= 3'd3);
                    vout_next.corner       = (v_reg >= 3'd3) ? 2'(v_reg - 3'd3) : 2'(v_reg);
                    vout_next.last         = (v_reg == 3'd5);
                    vout_next.mesh_done    = (v_reg == 3'd5) && final_reg;
                    vvalid_next            = 1'b1;
                    state_next             = S_VWAIT;
                end
            S_VWAIT:
            begin
                if (v_reg == 3'd5)
                begin
                    if (pj_reg + IW'(1) >= n)
                    begin
                        pj_next = '0;
                        ti_next = (ti_reg + IW'(1) >= n) ? '0 : ti_reg + IW'(1);
                    end
                    else
                        pj_next = pj_reg + IW'(1);
                    state_next = S_WAIT4;
                end
                else
                begin
                    v_next     = v_reg + 3'd1;
                    vpass_next = 1'b0;
                    state_next = S_WAIT3;
                end
            end
            S_WAIT4:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ti_reg     <= '0;
            pj_reg     <= '0;
            vvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ti_reg     <= ti_next;
            pj_reg     <= pj_next;
            vvalid_reg <= vvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ang_reg   <= ang_next;
        cosp_reg  <= cosp_next;
        k_reg     <= k_next;
        quad_reg  <= quad_next;
        x_reg     <= x_next;
        x2_reg    <= x2_next;
        t_reg     <= t_next;
        us_reg    <= us_next;
        sc_reg    <= sc_next;
        cc_reg    <= cc_next;
        v_reg     <= v_next;
        vpass_reg <= vpass_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        final_reg <= final_next;
        vout_reg  <= vout_next;
    end

    assign out_valid = vvalid_reg;
    assign out_data  = vout_reg;

`ifndef SYNTHESIS
    a_units_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(dctl.start && mctl.start)) else $error("both units started at once");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(dctl.start && dctl.busy) && !(mctl.start && mctl.busy))
        else $error("unit restarted while busy");
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> ti_reg < n && pj_reg < n)
        else $error("cell counter out of range");
`endif
endmodule
